FILE: rtl/txcon_pkg.sv
// Shared types and constants for the text console writer.
package txcon_pkg;

    localparam int ACT_W  = 2;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int IDX_W  = 11;
    localparam int CUR_W  = 11;
    localparam int DATA_W = 16;

    localparam logic [ACT_W-1:0] ACT_PUT   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;
    localparam logic [DATA_W-1:0] BLANK_CELL   = 16'h0F00;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic clear_step;
        logic scroll_step;
        logic fill_step;
        logic post;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic go_clear;
        logic go_scroll;
        logic sweep_last;
        logic scroll_last;
        logic out_free;
    } t_dp_status;

endpackage

FILE: rtl/txcon_in_if.sv
// Input item channel: action and its operands.
interface txcon_in_if import txcon_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [CHAR_W-1:0] character;
    logic [ATTR_W-1:0] attribute;
    logic [IDX_W-1:0]  cell_index;

    modport source (output valid, action, character, attribute, cell_index, input ready);
    modport sink   (input valid, action, character, attribute, cell_index, output ready);
endinterface

FILE: rtl/txcon_out_if.sv
// Result item channel: cursor and read data.
interface txcon_out_if import txcon_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CUR_W-1:0]  cursor_position;
    logic [DATA_W-1:0] read_data;

    modport source (output valid, cursor_position, read_data, input ready);
    modport sink   (input valid, cursor_position, read_data, output ready);
endinterface

FILE: rtl/txcon_ram.sv
// Generic single-write, single-read RAM with registered read data.
module txcon_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/txcon_ctrl.sv
// Sequencing state machine: accept, clear sweep, scroll copy, bottom fill, result post.
module txcon_ctrl import txcon_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_st,
    output t_dp_cmd    o_cmd
);
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CLEAR  = 5'b00010,
        ST_SCROLL = 5'b00100,
        ST_FILL   = 5'b01000,
        ST_POST   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_post_after, n_post_after;

    always_comb begin
        n_state      = r_state;
        n_post_after = r_post_after;
        o_cmd        = '0;
        o_in_ready   = (r_state == ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_st.go_clear) begin
                        n_state      = ST_CLEAR;
                        n_post_after = 1'b1;
                    end else if (i_st.go_scroll) begin
                        n_state = ST_SCROLL;
                    end else begin
                        n_state = ST_POST;
                    end
                end
            end
            ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                // the sweep after reset has no item to answer
                if (i_st.sweep_last) begin
                    n_state = r_post_after ? ST_POST : ST_IDLE;
                end
            end
            ST_SCROLL: begin
                o_cmd.scroll_step = 1'b1;
                if (i_st.scroll_last) begin
                    n_state = ST_FILL;
                end
            end
            ST_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_st.sweep_last) begin
                    n_state = ST_POST;
                end
            end
            ST_POST: begin
                if (i_st.out_free) begin
                    o_cmd.post = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_post_after <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_post_after <= n_post_after;
        end
    end
endmodule

FILE: rtl/txcon_dp.sv
// Datapath: cursor and column, sweep pointer, cell store ports, result register.
module txcon_dp import txcon_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_status        o_st,
    input  logic [ACT_W-1:0]  i_action,
    input  logic [CHAR_W-1:0] i_character,
    input  logic [ATTR_W-1:0] i_attribute,
    input  logic [IDX_W-1:0]  i_cell_index,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [CUR_W-1:0]  o_cursor_position,
    output logic [DATA_W-1:0] o_read_data
);
    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int COLW  = $clog2(COLUMNS);

    localparam logic [AW-1:0]   LAST_CELL  = AW'(CELLS - 1);
    localparam logic [AW-1:0]   SCROLL_END = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0]   COLS_A     = AW'(COLUMNS);
    localparam logic [COLW-1:0] LAST_COL   = COLW'(COLUMNS - 1);
    localparam logic [AW:0]     CELLS_X    = (AW + 1)'(CELLS);

    logic [AW-1:0]     r_cursor;
    logic [COLW-1:0]   r_col;
    logic [AW-1:0]     r_ptr;
    logic              r_pend;
    logic [AW-1:0]     r_pend_addr;
    logic              r_read_ok;
    logic              r_out_valid;
    logic [CUR_W-1:0]  r_out_cursor;
    logic [DATA_W-1:0] r_out_data;

    logic              is_put, is_nl, need_scroll, idx_ok, scroll_rd;
    logic [AW:0]       step_next;
    logic [31:0]       idx_ext, cur_ext;
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [DATA_W-1:0] ram_wdata, ram_rdata;

    always_comb begin
        is_put  = (i_action == ACT_PUT);
        is_nl   = (i_character == NEWLINE_CHAR);
        // newline jumps to the next row start, otherwise one cell on
        step_next = is_nl ? ({1'b0, r_cursor} + (AW + 1)'(COLUMNS) - (AW + 1)'(r_col))
                          : ({1'b0, r_cursor} + (AW + 1)'(1));
        need_scroll = (step_next >= CELLS_X);
        idx_ext     = 32'(i_cell_index);
        idx_ok      = (idx_ext < 32'(CELLS));
        cur_ext     = 32'(r_cursor);
        scroll_rd   = (r_ptr < SCROLL_END);

        o_st.go_clear    = (i_action == ACT_CLEAR);
        o_st.go_scroll   = is_put && need_scroll;
        o_st.sweep_last  = (r_ptr == LAST_CELL);
        o_st.scroll_last = (r_ptr == SCROLL_END);
        o_st.out_free    = !r_out_valid || i_out_ready;
    end

    // store port selection
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_ptr;
        ram_wdata = BLANK_CELL;
        ram_re    = 1'b0;
        ram_raddr = idx_ext[AW-1:0];
        if (i_cmd.accept && is_put && !is_nl) begin
            ram_we    = 1'b1;
            ram_waddr = r_cursor;
            ram_wdata = {i_attribute, i_character};
        end
        if (i_cmd.accept && i_action == ACT_READ && idx_ok) begin
            ram_re = 1'b1;
        end
        if (i_cmd.clear_step || i_cmd.fill_step) begin
            ram_we = 1'b1;
        end
        if (i_cmd.scroll_step) begin
            // read row below, write the registered read data one row up
            ram_we    = r_pend;
            ram_waddr = r_pend_addr;
            ram_wdata = ram_rdata;
            ram_re    = scroll_rd;
            ram_raddr = r_ptr + COLS_A;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor    <= '0;
            r_col       <= '0;
            r_ptr       <= '0;
            r_pend      <= 1'b0;
            r_read_ok   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= i_cmd.scroll_step && scroll_rd;
            if (i_cmd.accept) begin
                r_ptr     <= '0;
                r_read_ok <= (i_action == ACT_READ) && idx_ok;
                case (i_action)
                    ACT_PUT: begin
                        if (need_scroll) begin
                            r_cursor <= SCROLL_END;
                            r_col    <= '0;
                        end else begin
                            r_cursor <= step_next[AW-1:0];
                            r_col    <= (is_nl || r_col == LAST_COL) ? '0 : r_col + 1'b1;
                        end
                    end
                    ACT_CLEAR: begin
                        r_cursor <= '0;
                        r_col    <= '0;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.clear_step || i_cmd.fill_step || (i_cmd.scroll_step && scroll_rd)) begin
                r_ptr <= r_ptr + 1'b1;
            end
            if (i_cmd.post) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_addr <= r_ptr;
        if (i_cmd.post) begin
            r_out_cursor <= cur_ext[CUR_W-1:0];
            r_out_data   <= r_read_ok ? ram_rdata : '0;
        end
    end

    txcon_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid       = r_out_valid;
    assign o_cursor_position = r_out_cursor;
    assign o_read_data       = r_out_data;
endmodule

FILE: rtl/text_console_writer_top.sv
// Top level of the text console writer: controller, datapath and checks.
//
//  port     dir  modport  payload
//  i_in     in   sink     action, character, attribute, cell_index
//  o_out    out  source   cursor_position, read_data
//
// Put, newline, read and unused codes go through accept, then result load.
// Clear sweeps every cell, and a put that scrolls copies each row up and blanks the
// bottom row; both are set by the single write port of the cell store, one cell per cycle.
// After reset a clearing pass over all cells runs before the first item.
// A result waits in the output register while the next item is accepted;
// a new result is loaded only once that register is free.
module text_console_writer_top import txcon_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    txcon_in_if.sink    i_in,
    txcon_out_if.source o_out
);
    localparam int CELLS = ROWS * COLUMNS;

    t_dp_cmd    cmd;
    t_dp_status st;
    logic       in_ready;

    txcon_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    txcon_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_st              (st),
        .i_action          (i_in.action),
        .i_character       (i_in.character),
        .i_attribute       (i_in.attribute),
        .i_cell_index      (i_in.cell_index),
        .o_out_valid       (o_out.valid),
        .i_out_ready       (o_out.ready),
        .o_cursor_position (o_out.cursor_position),
        .o_read_data       (o_out.read_data)
    );

    assign i_in.ready = in_ready;

    // one job step per cycle
    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.accept, cmd.clear_step, cmd.scroll_step, cmd.fill_step, cmd.post}))
        else $error("more than one datapath step at once");

    a_post_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.post |-> st.out_free)
        else $error("result loaded over an untaken result");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("item accepted while previous item still at work");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (32'(o_out.cursor_position) < 32'(CELLS)))
        else $error("reported cursor beyond the store");
endmodule

FILE: bench/tb.sv
// Testbench for text_console_writer_top: predicts each result and checks it in order.
module tb;
    import txcon_pkg::*;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    localparam int IDLE_PCT       = 13;
    localparam int WATCHDOG_LIMIT = 20 * (CELLS + 3);
    localparam int DRAIN_CYCLES   = CELLS + 8;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        logic [CUR_W-1:0]  cursor_position;
        logic [DATA_W-1:0] read_data;
    } t_console_result;

    logic i_clk;
    logic i_rst_n;

    txcon_in_if  in_if ();
    txcon_out_if out_if ();

    text_console_writer_top #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    // predicted console contents
    logic [DATA_W-1:0] screen [CELLS];
    int unsigned       cursor_cell;

    t_console_result pending_results[$];

    bit no_idle;
    int fail_count;
    int result_count;
    int stall_cycles;
    int n_put, n_newline, n_clear, n_read, n_read_beyond, n_unused, n_scroll;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic void blank_screen();
        for (int i = 0; i < CELLS; i++)
            screen[i] = BLANK_CELL;
        cursor_cell = 0;
    endfunction

    function automatic void write_char(logic [CHAR_W-1:0] ch, logic [ATTR_W-1:0] attr);
        if (ch == NEWLINE_CHAR) begin
            cursor_cell += COLUMNS - (cursor_cell % COLUMNS);
        end else begin
            screen[cursor_cell] = {attr, ch};
            cursor_cell++;
        end
        // past the last cell: scroll up one row, blank the bottom row
        if (cursor_cell >= CELLS) begin
            for (int i = 0; i < CELLS - COLUMNS; i++)
                screen[i] = screen[i + COLUMNS];
            for (int i = CELLS - COLUMNS; i < CELLS; i++)
                screen[i] = BLANK_CELL;
            cursor_cell = CELLS - COLUMNS;
            n_scroll++;
        end
    endfunction

    function automatic t_console_result console_step(logic [ACT_W-1:0] act,
                                                     logic [CHAR_W-1:0] ch,
                                                     logic [ATTR_W-1:0] attr,
                                                     logic [IDX_W-1:0] idx);
        t_console_result r;
        r.read_data = '0;
        case (act)
            ACT_PUT: begin
                write_char(ch, attr);
                if (ch == NEWLINE_CHAR) n_newline++;
                else n_put++;
            end
            ACT_CLEAR: begin
                blank_screen();
                n_clear++;
            end
            ACT_READ: begin
                if (idx < CELLS) r.read_data = screen[idx];
                else n_read_beyond++;
                n_read++;
            end
            default: n_unused++;
        endcase
        r.cursor_position = cursor_cell[CUR_W-1:0];
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Driving
    // ---------------------------------------------------------------
    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(logic [ACT_W-1:0] act, logic [CHAR_W-1:0] ch,
                             logic [ATTR_W-1:0] attr, logic [IDX_W-1:0] idx);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.action     <= act;
        in_if.character  <= ch;
        in_if.attribute  <= attr;
        in_if.cell_index <= idx;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        pending_results.push_back(console_step(act, ch, attr, idx));
        @(negedge i_clk);
    endtask

    task automatic put_char(logic [CHAR_W-1:0] ch, logic [ATTR_W-1:0] attr);
        send_item(ACT_PUT, ch, attr, IDX_W'($urandom));
    endtask

    task automatic read_cell(logic [IDX_W-1:0] idx);
        send_item(ACT_READ, CHAR_W'($urandom), ATTR_W'($urandom), idx);
    endtask

    // read address: mostly near the cursor or anywhere on screen, some past the end
    function automatic logic [IDX_W-1:0] pick_index();
        int unsigned lo;
        int unsigned sel;
        sel = $urandom_range(99);
        lo  = (cursor_cell > 100) ? cursor_cell - 100 : 0;
        if (sel < 35) return IDX_W'($urandom_range(cursor_cell, lo));
        if (sel < 85) return IDX_W'($urandom_range(CELLS - 1));
        return IDX_W'($urandom);
    endfunction

    task automatic random_item();
        int unsigned sel;
        logic [CHAR_W-1:0] ch;
        sel = $urandom_range(99);
        ch  = ($urandom_range(99) < 15) ? NEWLINE_CHAR : CHAR_W'($urandom);
        if (sel < 58)
            put_char(ch, ATTR_W'($urandom));
        else if (sel < 90)
            read_cell(pick_index());
        else if (sel < 93)
            send_item(ACT_CLEAR, CHAR_W'($urandom), ATTR_W'($urandom), IDX_W'($urandom));
        else
            send_item(ACT_UNUSED, CHAR_W'($urandom), ATTR_W'($urandom), IDX_W'($urandom));
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_directed();
        read_cell(IDX_W'(0));
        read_cell(IDX_W'(CELLS - 1));
        read_cell(IDX_W'(CELLS));         // first index past the store
        read_cell('1);
        put_char(8'h00, 8'h00);
        put_char(8'hFF, 8'hFF);
        put_char(NEWLINE_CHAR, 8'hFF);    // newline is not stored
        put_char(8'h41, 8'h1E);
        read_cell(IDX_W'(0));
        read_cell(IDX_W'(1));
        read_cell(IDX_W'(2));
        read_cell(IDX_W'(COLUMNS));
        send_item(ACT_UNUSED, '1, '1, '1);
        send_item(ACT_UNUSED, '0, '0, '0);
        send_item(ACT_CLEAR, '1, '1, '1);
        read_cell(IDX_W'(1));
        put_char(NEWLINE_CHAR, 8'h00);    // newline at column 0
        put_char(8'h55, 8'hAA);
        read_cell(IDX_W'(COLUMNS));
    endtask

    // walk the cursor to the bottom row, then write text so the screen scrolls
    task automatic test_scroll_runs(int n_items);
        int start;
        int burst;
        start = result_count + pending_results.size();
        while (result_count + pending_results.size() - start < n_items) begin
            while (cursor_cell < CELLS - COLUMNS)
                put_char(NEWLINE_CHAR, ATTR_W'($urandom));
            burst = $urandom_range(120, 1);
            repeat (burst) begin
                if ($urandom_range(99) < 5) put_char(NEWLINE_CHAR, ATTR_W'($urandom));
                else put_char(CHAR_W'($urandom), ATTR_W'($urandom));
            end
            repeat (3) read_cell(IDX_W'($urandom_range(2 * COLUMNS - 1)));
            repeat (3) read_cell(IDX_W'($urandom_range(CELLS - 1, CELLS - COLUMNS)));
        end
    endtask

    task automatic test_random_mix(int n_items);
        repeat (n_items) random_item();
    endtask

    task automatic test_streaming(int n_items);
        no_idle = 1'b1;
        repeat (n_items) random_item();
        no_idle = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_console_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result: cursor %0d read_data %h",
                             out_if.cursor_position, out_if.read_data);
            end else begin
                want = pending_results.pop_front();
                if (out_if.cursor_position !== want.cursor_position ||
                    out_if.read_data !== want.read_data) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("result %0d: cursor exp %0d got %0d, read_data exp %h got %h",
                                 result_count, want.cursor_position,
                                 out_if.cursor_position, want.read_data, out_if.read_data);
                end
            end
            result_count++;
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles, %0d results pending",
                     stall_cycles, pending_results.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // receiver back-pressure
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.action     = '0;
        in_if.character  = '0;
        in_if.attribute  = '0;
        in_if.cell_index = '0;
        no_idle          = 1'b0;
        fail_count       = 0;
        result_count     = 0;
        stall_cycles     = 0;
        blank_screen();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_scroll_runs(320);
        test_random_mix(950);
        test_streaming(260);

        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (pending_results.size() != 0) begin
            fail_count += pending_results.size();
            $display("%0d results never arrived", pending_results.size());
        end
        $display("covered %0d results: %0d chars, %0d newlines, %0d clears, %0d unused codes",
                 result_count, n_put, n_newline, n_clear, n_unused);
        $display("  %0d reads (%0d past the store), %0d scrolls", n_read, n_read_beyond, n_scroll);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: sim.f
rtl/txcon_pkg.sv
rtl/txcon_in_if.sv
rtl/txcon_out_if.sv
rtl/txcon_ram.sv
rtl/txcon_ctrl.sv
rtl/txcon_dp.sv
rtl/text_console_writer_top.sv
bench/tb.sv
